// ===== src/hptq_pkg.sv =====
// hptq_pkg: shared types, widths and codes of the hand position tracking qualifier
// no dependencies; used by hptq_front, hptq_back and the top module
package hptq_pkg;

  localparam int RING_DEPTH_DEF = 15;

  localparam int POS_W      = 16;
  localparam int ENTRY_W    = 17;
  localparam int HANDS_W    = 4;
  localparam int OFF_W      = 4;
  localparam int FAIL_W     = 8;
  localparam int FRZ_W      = 16;
  localparam int STATE_W    = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_FAIL_LIMIT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FREEZE_FRAMES = 1'b1;

  localparam logic [FAIL_W-1:0] FAIL_LIMIT_RST    = 8'd4;
  localparam logic [FRZ_W-1:0]  FREEZE_FRAMES_RST = 16'd120;

  typedef enum logic [STATE_W-1:0] {
    MODE_UNAVAILABLE = 2'd0,
    MODE_BOOTING     = 2'd1,
    MODE_TRACKING    = 2'd2,
    MODE_FREEZING    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_EXEC,
    B_SUM,
    B_SUMEND,
    B_DIVGO,
    B_DIV,
    B_RD,
    B_OUT
  } bstate_t;

  // one queued word, already classified by the front
  typedef struct packed {
    logic                    is_read;
    logic                    store;
    logic                    no_hands;
    logic                    multi;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [OFF_W-1:0]        read_offset;
  } item_t;

endpackage

// ===== src/hptq_ram.sv =====
// hptq_ram: generic single write port, single read port ram with registered read
// no dependencies
module hptq_ram #(
  parameter int WIDTH = 51,
  parameter int DEPTH = 15
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/hptq_cdiv.sv =====
// hptq_cdiv: signed division by a constant, truncating toward zero, by reciprocal multiplication
// start is registered into stage_r and then done_r; depends on nothing but its parameters
module hptq_cdiv #(
  parameter int W       = 21,
  parameter int DIVISOR = 15
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start_i,
  input  logic signed [W-1:0] num_i,
  output logic                done_o,
  output logic signed [W-1:0] quot_o
);

  // |n| * RECIP >> SH equals |n| / DIVISOR for every |n| below 2**W
  localparam int     LG    = (DIVISOR > 1) ? $clog2(DIVISOR) : 0;
  localparam int     SH    = W + LG;
  localparam int     MW    = W + 2;
  localparam int     PRW   = W + SH;
  localparam longint RECIP = ((longint'(1) << SH) + longint'(DIVISOR) - longint'(1)) /
                             longint'(DIVISOR);
  localparam logic [MW-1:0] RECIP_C = MW'(RECIP);

  logic           stage_r, done_r;
  logic           neg_r;
  logic [W-1:0]   mag_r;
  logic [PRW-1:0] prod_r;
  logic [W-1:0]   num_mag;

  assign num_mag = num_i[W-1] ? -num_i : num_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      stage_r <= start_i;
      done_r  <= stage_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      neg_r <= num_i[W-1];
      mag_r <= num_mag;
    end
    if (stage_r) begin
      prod_r <= PRW'(mag_r) * PRW'(RECIP_C);
    end
  end

  assign done_o = done_r;
  assign quot_o = neg_r ? -$signed(prod_r[PRW-1:SH]) : $signed(prod_r[PRW-1:SH]);

endmodule

// ===== src/hptq_front.sv =====
// hptq_front: input acceptance, item classification and a two word queue
// depends on hptq_pkg
module hptq_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_kind,
  input  logic [hptq_pkg::HANDS_W-1:0]  in_hand_count,
  input  logic                          in_tracked_match,
  input  logic signed [hptq_pkg::POS_W-1:0] in_pos_x,
  input  logic signed [hptq_pkg::POS_W-1:0] in_pos_y,
  input  logic signed [hptq_pkg::POS_W-1:0] in_pos_z,
  input  logic [hptq_pkg::OFF_W-1:0]    in_read_offset,
  output logic                          q_valid,
  output hptq_pkg::item_t               q_item,
  input  logic                          q_pop
);

  localparam int QD = 2;

  hptq_pkg::item_t q_mem_r [QD];
  logic            wr_ptr_r, rd_ptr_r;
  logic [1:0]      cnt_r;
  logic            push;
  hptq_pkg::item_t item_in;

  always_comb begin
    item_in.is_read     = (in_kind == hptq_pkg::KIND_READ);
    item_in.no_hands    = (in_hand_count == '0);
    item_in.multi       = (in_hand_count > hptq_pkg::HANDS_W'(1));
    // a match only counts when some hand is seen
    item_in.store       = in_tracked_match && (in_hand_count != '0);
    item_in.pos_x       = in_pos_x;
    item_in.pos_y       = in_pos_y;
    item_in.pos_z       = in_pos_z;
    item_in.read_offset = in_read_offset;
  end

  assign in_ready = (cnt_r != 2'(QD));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != '0);
  assign q_item   = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, q_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

// ===== src/hptq_back.sv =====
// hptq_back: qualifier state machine, position ring, centering and result register
// depends on hptq_pkg, hptq_ram and hptq_cdiv
module hptq_back #(
  parameter int RING_DEPTH = hptq_pkg::RING_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [hptq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hptq_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              q_valid,
  input  hptq_pkg::item_t                   q_item,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [hptq_pkg::STATE_W-1:0]      out_tracker_state,
  output logic signed [hptq_pkg::ENTRY_W-1:0] out_x,
  output logic signed [hptq_pkg::ENTRY_W-1:0] out_y,
  output logic signed [hptq_pkg::ENTRY_W-1:0] out_z
);

  localparam int EW    = hptq_pkg::ENTRY_W;
  localparam int PW    = hptq_pkg::POS_W;
  localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int BC_W  = $clog2(RING_DEPTH + 1);
  localparam int SUM_W = EW + $clog2(RING_DEPTH);
  localparam int RAM_W = 3 * EW;
  localparam int OFF_N = 1 << hptq_pkg::OFF_W;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);
  localparam logic [IDX_W:0]   DEPTH_C  = (IDX_W + 1)'(RING_DEPTH);
  localparam logic [BC_W-1:0]  BC_FULL  = BC_W'(RING_DEPTH);
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32767);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-32768);

  hptq_pkg::bstate_t state_r, state_nxt;
  hptq_pkg::mode_t   mode_r, mode_nxt;
  logic [IDX_W-1:0]  wi_r, wi_nxt;
  logic [BC_W-1:0]   boot_r, boot_nxt;
  logic [hptq_pkg::FAIL_W-1:0] fail_r, fail_nxt;
  logic [hptq_pkg::FRZ_W-1:0]  frz_r, frz_nxt;
  logic signed [PW-1:0]        ctr_r [3];
  logic signed [PW-1:0]        ctr_nxt [3];
  hptq_pkg::item_t   item_r;
  logic [IDX_W-1:0]  addr_r, addr_nxt;
  logic [IDX_W-1:0]  sidx_r, sidx_nxt;
  logic              pend_r, pend_nxt;
  logic signed [SUM_W-1:0] sum_r [3];
  logic signed [SUM_W-1:0] sum_nxt [3];
  logic [RING_DEPTH-1:0]   valid_r, valid_nxt;
  logic              rvld_r;
  logic [hptq_pkg::FAIL_W-1:0] fail_limit_r;
  logic [hptq_pkg::FRZ_W-1:0]  freeze_frames_r;

  logic                     out_valid_r;
  logic [hptq_pkg::STATE_W-1:0] out_state_r;
  logic signed [EW-1:0]     out_e_r [3];
  logic                     out_load;

  logic                 ram_we, ram_re;
  logic [IDX_W-1:0]     ram_raddr;
  logic [RAM_W-1:0]     ram_wdata, ram_rdata;
  logic                 div_start;
  logic [2:0]           div_done;
  logic signed [SUM_W-1:0] quot [3];

  logic signed [PW-1:0] pos [3];
  logic signed [PW-1:0] ctr_eff [3];
  logic signed [EW-1:0] st_e [3];
  logic signed [EW-1:0] ent [3];
  logic [IDX_W-1:0]     off_mod [OFF_N];
  logic [IDX_W-1:0]     wi_inc;

  // read offsets folded into the ring at elaboration
  for (genvar g = 0; g < OFF_N; g++) begin : g_off
    assign off_mod[g] = IDX_W'(g % RING_DEPTH);
  end

  assign pos[0] = item_r.pos_x;
  assign pos[1] = item_r.pos_y;
  assign pos[2] = item_r.pos_z;

  for (genvar a = 0; a < 3; a++) begin : g_axis
    // booting from unavailable clears the center before the store
    assign ctr_eff[a] = (mode_r == hptq_pkg::MODE_UNAVAILABLE) ? '0 : ctr_r[a];
    assign st_e[a]    = {pos[a][PW-1], pos[a]} - {ctr_eff[a][PW-1], ctr_eff[a]};
    assign ram_wdata[a*EW +: EW] = st_e[a];
    assign ent[a]     = rvld_r ? $signed(ram_rdata[a*EW +: EW]) : '0;

    hptq_cdiv #(
      .W       (SUM_W),
      .DIVISOR (RING_DEPTH)
    ) u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .start_i (div_start),
      .num_i   (sum_r[a]),
      .done_o  (div_done[a]),
      .quot_o  (quot[a])
    );
  end

  assign wi_inc = (wi_r == LAST_IDX) ? '0 : wi_r + 1'b1;

  hptq_ram #(
    .WIDTH (RAM_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wi_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    logic [IDX_W:0]  rsum;
    logic [IDX_W:0]  rdif;
    logic [BC_W-1:0] bc;
    hptq_pkg::mode_t m;
    logic            do_ctr;

    state_nxt = state_r;
    mode_nxt  = mode_r;
    wi_nxt    = wi_r;
    boot_nxt  = boot_r;
    fail_nxt  = fail_r;
    frz_nxt   = frz_r;
    addr_nxt  = addr_r;
    sidx_nxt  = sidx_r;
    pend_nxt  = pend_r;
    valid_nxt = valid_r;
    for (int a = 0; a < 3; a++) begin
      ctr_nxt[a] = ctr_r[a];
      sum_nxt[a] = sum_r[a];
    end
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = addr_r;
    q_pop     = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    rsum      = '0;
    rdif      = '0;
    bc        = boot_r;
    m         = mode_r;
    do_ctr    = 1'b0;

    unique case (state_r)
      hptq_pkg::B_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          state_nxt = hptq_pkg::B_EXEC;
        end
      end
      hptq_pkg::B_EXEC: begin
        if (item_r.is_read) begin
          rsum      = {1'b0, wi_r} + {1'b0, off_mod[item_r.read_offset]};
          rdif      = rsum - DEPTH_C;
          addr_nxt  = (rsum >= DEPTH_C) ? rdif[IDX_W-1:0] : rsum[IDX_W-1:0];
          state_nxt = hptq_pkg::B_RD;
        end else begin
          if (mode_r == hptq_pkg::MODE_FREEZING) begin
            // frame discarded, only the freeze countdown moves; at zero the mode returns to unavailable
            frz_nxt = (frz_r != '0) ? frz_r - 1'b1 : '0;
            if (frz_nxt == '0) begin
              mode_nxt = hptq_pkg::MODE_UNAVAILABLE;
              fail_nxt = '0;
            end
          end else begin
            if (item_r.store) begin
              if (m == hptq_pkg::MODE_UNAVAILABLE) begin
                m        = hptq_pkg::MODE_BOOTING;
                bc       = '0;
                fail_nxt = '0;
                for (int a = 0; a < 3; a++) begin
                  ctr_nxt[a] = '0;
                end
              end
              ram_we          = 1'b1;
              valid_nxt[wi_r] = 1'b1;
              wi_nxt          = wi_inc;
              if (bc < BC_FULL) begin
                bc = bc + 1'b1;
              end
              if (m == hptq_pkg::MODE_BOOTING && bc == BC_FULL) begin
                m      = hptq_pkg::MODE_TRACKING;
                do_ctr = 1'b1;
              end
            end
            if (item_r.no_hands) begin
              if (fail_r >= fail_limit_r) begin
                m        = hptq_pkg::MODE_UNAVAILABLE;
                fail_nxt = '0;
              end else begin
                fail_nxt = fail_r + 1'b1;
              end
            end else if (item_r.multi) begin
              if (freeze_frames_r == '0) begin
                m        = hptq_pkg::MODE_UNAVAILABLE;
                fail_nxt = '0;
              end else begin
                m       = hptq_pkg::MODE_FREEZING;
                frz_nxt = freeze_frames_r;
              end
            end
            mode_nxt = m;
            boot_nxt = bc;
          end
          // frames report the entry just before the write index
          addr_nxt = (wi_nxt == '0) ? LAST_IDX : wi_nxt - 1'b1;
          sidx_nxt = '0;
          pend_nxt = 1'b0;
          for (int a = 0; a < 3; a++) begin
            sum_nxt[a] = '0;
          end
          state_nxt = do_ctr ? hptq_pkg::B_SUM : hptq_pkg::B_RD;
        end
      end
      hptq_pkg::B_SUM: begin
        ram_re    = 1'b1;
        ram_raddr = sidx_r;
        if (pend_r) begin
          for (int a = 0; a < 3; a++) begin
            sum_nxt[a] = sum_r[a] + SUM_W'(ent[a]);
          end
        end
        pend_nxt = 1'b1;
        sidx_nxt = sidx_r + 1'b1;
        if (sidx_r == LAST_IDX) begin
          state_nxt = hptq_pkg::B_SUMEND;
        end
      end
      hptq_pkg::B_SUMEND: begin
        for (int a = 0; a < 3; a++) begin
          sum_nxt[a] = sum_r[a] + SUM_W'(ent[a]);
        end
        state_nxt = hptq_pkg::B_DIVGO;
      end
      hptq_pkg::B_DIVGO: begin
        div_start = 1'b1;
        state_nxt = hptq_pkg::B_DIV;
      end
      hptq_pkg::B_DIV: begin
        if (&div_done) begin
          for (int a = 0; a < 3; a++) begin
            if (quot[a] > SAT_HI) begin
              ctr_nxt[a] = SAT_HI[PW-1:0];
            end else if (quot[a] < SAT_LO) begin
              ctr_nxt[a] = SAT_LO[PW-1:0];
            end else begin
              ctr_nxt[a] = quot[a][PW-1:0];
            end
          end
          state_nxt = hptq_pkg::B_RD;
        end
      end
      hptq_pkg::B_RD: begin
        ram_re    = 1'b1;
        state_nxt = hptq_pkg::B_OUT;
      end
      hptq_pkg::B_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = hptq_pkg::B_IDLE;
        end
      end
      default: state_nxt = hptq_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= hptq_pkg::B_IDLE;
      mode_r          <= hptq_pkg::MODE_UNAVAILABLE;
      wi_r            <= '0;
      boot_r          <= '0;
      fail_r          <= '0;
      frz_r           <= '0;
      valid_r         <= '0;
      out_valid_r     <= 1'b0;
      pend_r          <= 1'b0;
      sidx_r          <= '0;
      fail_limit_r    <= hptq_pkg::FAIL_LIMIT_RST;
      freeze_frames_r <= hptq_pkg::FREEZE_FRAMES_RST;
      for (int a = 0; a < 3; a++) begin
        ctr_r[a] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      wi_r    <= wi_nxt;
      boot_r  <= boot_nxt;
      fail_r  <= fail_nxt;
      frz_r   <= frz_nxt;
      valid_r <= valid_nxt;
      pend_r  <= pend_nxt;
      sidx_r  <= sidx_nxt;
      for (int a = 0; a < 3; a++) begin
        ctr_r[a] <= ctr_nxt[a];
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          hptq_pkg::CFG_FAIL_LIMIT:    fail_limit_r    <= cfg_wdata[hptq_pkg::FAIL_W-1:0];
          hptq_pkg::CFG_FREEZE_FRAMES: freeze_frames_r <= cfg_wdata[hptq_pkg::FRZ_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= q_item;
    end
    addr_r <= addr_nxt;
    for (int a = 0; a < 3; a++) begin
      sum_r[a] <= sum_nxt[a];
    end
    // entries never written read as zero
    if (ram_re) begin
      rvld_r <= valid_r[ram_raddr];
    end
    if (out_load) begin
      out_state_r <= mode_r;
      for (int a = 0; a < 3; a++) begin
        out_e_r[a] <= ent[a];
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_tracker_state = out_state_r;
  assign out_x             = out_e_r[0];
  assign out_y             = out_e_r[1];
  assign out_z             = out_e_r[2];

endmodule

// ===== src/hand_position_tracking_qualifier_top.sv =====
// a read or a frame is popped in the idle state, then passes the exec, ring read and result
// states of the back; a frame that ends booting also walks the ring in the sum states and
// runs the reciprocal divide before the ring read
// the back takes no new word until the last one's result is loaded into the output register
// reset: synchronous active low; clears state, counters, center and ring valid bits,
// and loads the register defaults; ring contents are not swept
module hand_position_tracking_qualifier_top #(
  parameter int RING_DEPTH = hptq_pkg::RING_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [hptq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hptq_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_kind,
  input  logic [hptq_pkg::HANDS_W-1:0]        in_hand_count,
  input  logic                                in_tracked_match,
  input  logic signed [hptq_pkg::POS_W-1:0]   in_pos_x,
  input  logic signed [hptq_pkg::POS_W-1:0]   in_pos_y,
  input  logic signed [hptq_pkg::POS_W-1:0]   in_pos_z,
  input  logic [hptq_pkg::OFF_W-1:0]          in_read_offset,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [hptq_pkg::STATE_W-1:0]        out_tracker_state,
  output logic signed [hptq_pkg::ENTRY_W-1:0] out_x,
  output logic signed [hptq_pkg::ENTRY_W-1:0] out_y,
  output logic signed [hptq_pkg::ENTRY_W-1:0] out_z
);

  logic            q_valid;
  logic            q_pop;
  hptq_pkg::item_t q_item;

  hptq_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_hand_count    (in_hand_count),
    .in_tracked_match (in_tracked_match),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_pos_z         (in_pos_z),
    .in_read_offset   (in_read_offset),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop)
  );

  hptq_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_tracker_state (out_tracker_state),
    .out_x             (out_x),
    .out_y             (out_y),
    .out_z             (out_z)
  );

  // the back never takes a word from an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // a full queue must present a word
  a_full_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> q_valid)
    else $error("queue full but not valid");

  // the back never pops two words in a row
  a_pop_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> !q_pop)
    else $error("back popped two words in a row");

endmodule
